FILE: src/skt_pkg.sv
// skt_pkg: sizes, record and memory-port types and status codes of the
// sorted key table. Used by skt_store and sorted_key_table.
package skt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int KEY_W     = 64;
	localparam int CODE_W    = 8;
	localparam int VAL_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 6;
	localparam int ENTRIES_W = 7;
	localparam int LIMIT_W   = 7;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CODE_W-1:0] dtype;
		logic [VAL_W-1:0]  low;
		logic [VAL_W-1:0]  high;
		logic [VAL_W-1:0]  step;
		logic [CODE_W-1:0] fid;
	} rec_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		rec_t             wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

FILE: src/skt_store.sv
// skt_store: record memory of the sorted key table with separate write and
// read addresses, one write and one registered read per cycle. Depends on skt_pkg.
module skt_store import skt_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output rec_t     rd_data
);

	rec_t mem [TABLE_DEPTH];
	rec_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: src/sorted_key_table.sv
// sorted_key_table: records kept in ascending order of a 64-bit key in one
// record memory, with insert and lookup commands. Depends on skt_pkg
// and skt_store.
//
// Each input word is an insert (cmd 0) or a lookup (cmd 1) and gives one
// result word. The table is walked from slot 0 through one shared compare
// unit: every record compared is first read from memory, then compared,
// and an insert moves each later record up one slot (memory read, then
// write) before it writes the new record. An insert refused as full skips
// the scan. in_stall stays high while a word is in work; a finished result
// waits in the output register and the next word is taken meanwhile.
// table_limit caps the record count (saturating at TABLE_DEPTH); write it
// only while the block is idle. Reset empties the table; memory contents
// are not cleared, since only slots below the count are ever read.
module sorted_key_table import skt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [LIMIT_W-1:0]   cfg_wr_data,
	// input words
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [KEY_W-1:0]     key,
	input  logic [CODE_W-1:0]    domain_type,
	input  logic [VAL_W-1:0]     low_limit,
	input  logic [VAL_W-1:0]     high_limit,
	input  logic [VAL_W-1:0]     step_value,
	input  logic [CODE_W-1:0]    fidelity_code,
	// result words
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    slot,
	output logic [CODE_W-1:0]    found_type,
	output logic [VAL_W-1:0]     found_low,
	output logic [VAL_W-1:0]     found_high,
	output logic [VAL_W-1:0]     found_step,
	output logic [CODE_W-1:0]    found_fidelity,
	output logic [ENTRIES_W-1:0] entries
);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0; // waiting for a word
	localparam logic [2:0] S_RD   = 3'd1; // read the record at idx_q
	localparam logic [2:0] S_CMP  = 3'd2; // compare its key
	localparam logic [2:0] S_SHRD = 3'd3; // read the record below ptr_q
	localparam logic [2:0] S_SHWR = 3'd4; // move it up into ptr_q
	localparam logic [2:0] S_INS  = 3'd5; // write the new record at idx_q
	localparam logic [2:0] S_OUT  = 3'd6; // hand the result to the output register

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                out_valid_q;

	// word in work
	logic                cmd_q;
	rec_t                item_q;
	logic [CNT_W-1:0]    idx_q;    // scan position, later the insert slot
	logic [CNT_W-1:0]    ptr_q;    // destination slot of the move
	logic [STATUS_W-1:0] res_status_q;
	rec_t                res_rec_q;

	// output register
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	rec_t                out_rec_q;
	logic [ENTRIES_W-1:0] out_entries_q;

	mem_req_t            mem_req;
	rec_t                rd_data;

	logic                accept;
	logic                table_full;
	logic                scan_done;
	logic                key_hit;
	logic                key_past;
	logic                out_free;
	logic [CNT_W-1:0]    ptr_dec;

	skt_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE);
	// capacity is min(table_limit, TABLE_DEPTH)
	assign table_full = (32'(count_q) >= 32'(limit_q)) || (32'(count_q) >= TABLE_DEPTH);
	assign scan_done  = (idx_q == count_q);
	assign key_hit    = (rd_data.key == item_q.key);
	assign key_past   = (rd_data.key > item_q.key);
	assign out_free   = !out_valid_q || !out_stall;
	assign ptr_dec    = ptr_q - 1'b1;

	// memory port
	always_comb begin
		mem_req = '0;
		case (state_q)
			S_RD: begin
				mem_req.re    = !scan_done;
				mem_req.raddr = IDX_W'(idx_q);
			end
			S_SHRD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = IDX_W'(ptr_dec);
			end
			S_SHWR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = IDX_W'(ptr_q);
				mem_req.wdata = rd_data;
			end
			S_INS: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = IDX_W'(idx_q);
				mem_req.wdata = item_q;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			// a new result takes the output register as the old one leaves
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cmd == CMD_INSERT && table_full) ? S_OUT : S_RD;
					end
				end
				S_RD: begin
					if (scan_done) begin
						// ran off the end: key not present
						if (cmd_q == CMD_INSERT) begin
							state_q <= (count_q == idx_q) ? S_INS : S_SHRD;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (key_hit) begin
						state_q <= S_OUT;
					end else if (key_past) begin
						if (cmd_q == CMD_INSERT) begin
							state_q <= (count_q == idx_q) ? S_INS : S_SHRD;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					state_q <= (ptr_dec == idx_q) ? S_INS : S_SHRD;
				end
				S_INS: begin
					count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q        <= cmd;
					item_q.key   <= key;
					item_q.dtype <= domain_type;
					item_q.low   <= low_limit;
					item_q.high  <= high_limit;
					item_q.step  <= step_value;
					item_q.fid   <= fidelity_code;
					idx_q        <= '0;
					ptr_q        <= count_q;
					res_rec_q    <= '0;
					res_status_q <= ST_FULL;
				end
			end
			S_RD: begin
				if (scan_done) begin
					res_status_q <= (cmd_q == CMD_INSERT) ? ST_OK : ST_MISS;
				end
			end
			S_CMP: begin
				if (key_hit) begin
					if (cmd_q == CMD_INSERT) begin
						res_status_q <= ST_DUP;
					end else begin
						res_status_q <= ST_OK;
						res_rec_q    <= rd_data;
					end
				end else if (key_past) begin
					res_status_q <= (cmd_q == CMD_INSERT) ? ST_OK : ST_MISS;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SHWR: begin
				ptr_q <= ptr_dec;
			end
			S_OUT: begin
				if (out_free) begin
					out_status_q  <= res_status_q;
					// slot reads zero for full and not-found results
					out_slot_q    <= (res_status_q == ST_FULL || res_status_q == ST_MISS) ?
						'0 : SLOT_W'(idx_q);
					out_rec_q     <= res_rec_q;
					out_entries_q <= ENTRIES_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign slot           = out_slot_q;
	assign found_type     = out_rec_q.dtype;
	assign found_low      = out_rec_q.low;
	assign found_high     = out_rec_q.high;
	assign found_step     = out_rec_q.step;
	assign found_fidelity = out_rec_q.fid;
	assign entries        = out_entries_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= TABLE_DEPTH)
		else $error("record count above table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
		else $error("record count moved by other than one");

	a_shift_above: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHWR) |-> (ptr_q > idx_q))
		else $error("record move at or below the insert slot");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result shown without a finished word");
`endif

endmodule

FILE: bench/tb_sorted_key_table.sv
// tb_sorted_key_table: self-checking bench for the sorted key table, with a directed
// table of words followed by random phases at several table limits
// depends on skt_pkg and sorted_key_table
module tb_sorted_key_table;
	import skt_pkg::*;

	localparam int RAND_PHASE_WORDS = 125;
	localparam int HOLD_CYCLES      = 800;
	localparam int DRAIN_CYCLES     = 300;
	localparam int TIMEOUT_CYCLES   = 1000000;

	// one input word: the command and the record it carries
	typedef struct packed {
		logic cmd;
		rec_t rec;
	} word_t;

	// one result word as the table answers it
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot;
		logic [CODE_W-1:0]    ftype;
		logic [VAL_W-1:0]     flow;
		logic [VAL_W-1:0]     fhigh;
		logic [VAL_W-1:0]     fstep;
		logic [CODE_W-1:0]    ffid;
		logic [ENTRIES_W-1:0] entries;
	} answer_t;

	typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_t;

	// directed row: a word or a limit write; pay spreads over the payload fields,
	// and the typed answer (payload zero) is used only where fixed is set
	typedef struct packed {
		row_kind_t            kind;
		logic                 cmd;
		logic [KEY_W-1:0]     key;
		logic [VAL_W-1:0]     pay;
		logic [LIMIT_W-1:0]   limit;
		logic                 fixed;
		logic [STATUS_W-1:0]  e_status;
		logic [SLOT_W-1:0]    e_slot;
		logic [ENTRIES_W-1:0] e_entries;
	} stim_row_t;

	localparam int N_ROWS = 27;

	stim_row_t directed_rows [N_ROWS] = '{
		// empty table: both key extremes miss
		'{ROW_WORD, CMD_LOOKUP, 64'h0, 32'h0, 7'd0, 1'b1, ST_MISS, 6'd0, 7'd0},
		'{ROW_WORD, CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 7'd0, 1'b1, ST_MISS,
			6'd0, 7'd0},
		// middle key first, then both ends around it
		'{ROW_WORD, CMD_INSERT, 64'h8000_0000_0000_0000, 32'hffff_ffff, 7'd0, 1'b1, ST_OK,
			6'd0, 7'd1},
		'{ROW_WORD, CMD_INSERT, 64'h0, 32'h0, 7'd0, 1'b1, ST_OK, 6'd0, 7'd2},
		'{ROW_WORD, CMD_INSERT, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 7'd0, 1'b1, ST_OK,
			6'd2, 7'd3},
		// duplicates at both ends
		'{ROW_WORD, CMD_INSERT, 64'h0, 32'h0000_1234, 7'd0, 1'b1, ST_DUP, 6'd0, 7'd3},
		'{ROW_WORD, CMD_INSERT, 64'hffff_ffff_ffff_ffff, 32'h0, 7'd0, 1'b1, ST_DUP, 6'd2, 7'd3},
		// hits, lookup payload inputs are don't-care
		'{ROW_WORD, CMD_LOOKUP, 64'h0, 32'hffff_ffff, 7'd0, 1'b0, ST_OK, 6'd0, 7'd0},
		'{ROW_WORD, CMD_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'h0, 7'd0, 1'b0, ST_OK, 6'd0, 7'd0},
		'{ROW_WORD, CMD_LOOKUP, 64'h8000_0000_0000_0000, 32'h0, 7'd0, 1'b0, ST_OK, 6'd0, 7'd0},
		// misses between held keys
		'{ROW_WORD, CMD_LOOKUP, 64'h1, 32'h0, 7'd0, 1'b1, ST_MISS, 6'd0, 7'd3},
		'{ROW_WORD, CMD_LOOKUP, 64'h7fff_ffff_ffff_ffff, 32'h0, 7'd0, 1'b1, ST_MISS, 6'd0, 7'd3},
		// inserts in the middle move later records up
		'{ROW_WORD, CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h5a3c_96e1, 7'd0, 1'b0, ST_OK,
			6'd0, 7'd0},
		'{ROW_WORD, CMD_INSERT, 64'h1, 32'ha5c3_691e, 7'd0, 1'b0, ST_OK, 6'd0, 7'd0},
		'{ROW_WORD, CMD_LOOKUP, 64'h7fff_ffff_ffff_ffff, 32'h0, 7'd0, 1'b0, ST_OK, 6'd0, 7'd0},
		'{ROW_WORD, CMD_LOOKUP, 64'h1, 32'h0, 7'd0, 1'b0, ST_OK, 6'd0, 7'd0},
		// limit below the count: full wins over duplicate, lookups still hit
		'{ROW_LIMIT, CMD_INSERT, 64'h0, 32'h0, 7'd0, 1'b0, ST_OK, 6'd0, 7'd0},
		'{ROW_WORD, CMD_INSERT, 64'h2, 32'h0, 7'd0, 1'b1, ST_FULL, 6'd0, 7'd5},
		'{ROW_WORD, CMD_INSERT, 64'h0, 32'h0, 7'd0, 1'b1, ST_FULL, 6'd0, 7'd5},
		'{ROW_WORD, CMD_LOOKUP, 64'h1, 32'h0, 7'd0, 1'b0, ST_OK, 6'd0, 7'd0},
		// limit equal to the count
		'{ROW_LIMIT, CMD_INSERT, 64'h0, 32'h0, 7'd5, 1'b0, ST_OK, 6'd0, 7'd0},
		'{ROW_WORD, CMD_INSERT, 64'h3, 32'h0, 7'd0, 1'b1, ST_FULL, 6'd0, 7'd5},
		// limit above the depth saturates
		'{ROW_LIMIT, CMD_INSERT, 64'h0, 32'h0, 7'd127, 1'b0, ST_OK, 6'd0, 7'd0},
		'{ROW_WORD, CMD_INSERT, 64'hffff_ffff_ffff_fffe, 32'h3c3c_3c3c, 7'd0, 1'b0, ST_OK,
			6'd0, 7'd0},
		'{ROW_LIMIT, CMD_INSERT, 64'h0, 32'h0, 7'd6, 1'b0, ST_OK, 6'd0, 7'd0},
		'{ROW_WORD, CMD_INSERT, 64'h4, 32'h0, 7'd0, 1'b1, ST_FULL, 6'd0, 7'd6},
		'{ROW_LIMIT, CMD_INSERT, 64'h0, 32'h0, 7'd64, 1'b0, ST_OK, 6'd0, 7'd0}
	};

	// limits of the random phases; the table only grows, so they climb overall
	logic [LIMIT_W-1:0] phase_limits [6] = '{7'd20, 7'd3, 7'd45, 7'd0, 7'd127, 7'd64};

	// block ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [LIMIT_W-1:0]   cfg_wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 cmd = CMD_INSERT;
	logic [KEY_W-1:0]     key = '0;
	logic [CODE_W-1:0]    domain_type = '0;
	logic [VAL_W-1:0]     low_limit = '0;
	logic [VAL_W-1:0]     high_limit = '0;
	logic [VAL_W-1:0]     step_value = '0;
	logic [CODE_W-1:0]    fidelity_code = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [SLOT_W-1:0]    slot;
	logic [CODE_W-1:0]    found_type;
	logic [VAL_W-1:0]     found_low;
	logic [VAL_W-1:0]     found_high;
	logic [VAL_W-1:0]     found_step;
	logic [CODE_W-1:0]    found_fidelity;
	logic [ENTRIES_W-1:0] entries;

	// bench copy of the table, kept in key order
	rec_t               held_recs [TABLE_DEPTH];
	int unsigned        held_count = 0;
	logic [LIMIT_W-1:0] limit_setting = LIMIT_RESET;

	answer_t answers_due [$];
	int      mismatch_count = 0;
	int      burst_left = 0;
	logic    hold_off_req = 1'b0;

	sorted_key_table DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.key            (key),
		.domain_type    (domain_type),
		.low_limit      (low_limit),
		.high_limit     (high_limit),
		.step_value     (step_value),
		.fidelity_code  (fidelity_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot           (slot),
		.found_type     (found_type),
		.found_low      (found_low),
		.found_high     (found_high),
		.found_step     (found_step),
		.found_fidelity (found_fidelity),
		.entries        (entries)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// applies one accepted word to the bench table and returns the answer it gives
	function automatic answer_t table_answer(input word_t w);
		answer_t     r;
		int unsigned cap;
		int unsigned pos;
		logic        hit;
		r = '0;
		hit = 1'b0;
		cap = (int'(limit_setting) < TABLE_DEPTH) ? int'(limit_setting) : TABLE_DEPTH;
		// first slot whose key is not below the word's key
		for (pos = 0; pos < held_count; pos++) begin
			if (held_recs[pos].key == w.rec.key) begin
				hit = 1'b1;
				break;
			end
			if (held_recs[pos].key > w.rec.key)
				break;
		end
		if (w.cmd == CMD_INSERT) begin
			if (held_count >= cap) begin
				// capacity takes precedence over the result of the key search
				r.status = ST_FULL;
			end else if (hit) begin
				r.status = ST_DUP;
				r.slot = pos[SLOT_W-1:0];
			end else begin
				for (int unsigned i = held_count; i > pos; i--)
					held_recs[i] = held_recs[i - 1];
				held_recs[pos] = w.rec;
				held_count++;
				r.status = ST_OK;
				r.slot = pos[SLOT_W-1:0];
			end
		end else if (hit) begin
			r.status = ST_OK;
			r.slot = pos[SLOT_W-1:0];
			r.ftype = held_recs[pos].dtype;
			r.flow = held_recs[pos].low;
			r.fhigh = held_recs[pos].high;
			r.fstep = held_recs[pos].step;
			r.ffid = held_recs[pos].fid;
		end else begin
			r.status = ST_MISS;
		end
		r.entries = held_count[ENTRIES_W-1:0];
		return r;
	endfunction

	// random key: held keys and their neighbours for hits and duplicates,
	// small keys (some with the top bit set) for collisions, else anything
	function automatic logic [KEY_W-1:0] pick_key(input logic for_insert);
		int unsigned      sel;
		int unsigned      reuse_pct;
		logic [KEY_W-1:0] k;
		sel = $urandom_range(0, 99);
		reuse_pct = for_insert ? 20 : 55;
		if (held_count != 0 && sel < reuse_pct + 15) begin
			k = held_recs[$urandom_range(0, held_count - 1)].key;
			if (sel >= reuse_pct)
				k = sel[0] ? k + 64'd1 : k - 64'd1;
		end else if (sel < 85) begin
			k = 64'($urandom_range(0, 127));
			k[KEY_W-1] = 1'($urandom_range(0, 1));
		end else begin
			k = {$urandom(), $urandom()};
		end
		return k;
	endfunction

	// offers one word in the sender's burst pattern and records its answer once taken;
	// called at a rising edge, returns at the edge where the word was accepted
	task automatic send_word(input word_t w, input logic fixed, input answer_t fixed_ans);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= w.cmd;
		key <= w.rec.key;
		domain_type <= w.rec.dtype;
		low_limit <= w.rec.low;
		high_limit <= w.rec.high;
		step_value <= w.rec.step;
		fidelity_code <= w.rec.fid;
		do
			@(posedge clk);
		while (in_stall);
		// the bench table always advances, the typed answer replaces its output
		if (fixed) begin
			void'(table_answer(w));
			answers_due.push_back(fixed_ans);
		end else begin
			answers_due.push_back(table_answer(w));
		end
	endtask

	// limit write, only once every answer is back and the block has settled
	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_setting = value;
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// receiver: stall mode changes every so often (none, light, heavy), with one
	// long hold-off on request so the block fills up and stalls its input
	initial begin : receiver
		int stall_mode;
		int mode_left;
		int hold_left;
		logic hold_done;
		stall_mode = 0;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 25);
					default: out_stall <= ($urandom_range(0, 99) < 75);
				endcase
			end
		end
	end

	// every result word taken is held against the oldest answer due
	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				$error("result word with no answer due");
				mismatch_count++;
			end else begin
				want = answers_due.pop_front();
				compare_field("status", 64'(want.status), 64'(status));
				compare_field("slot", 64'(want.slot), 64'(slot));
				compare_field("found_type", 64'(want.ftype), 64'(found_type));
				compare_field("found_low", 64'(want.flow), 64'(found_low));
				compare_field("found_high", 64'(want.fhigh), 64'(found_high));
				compare_field("found_step", 64'(want.fstep), 64'(found_step));
				compare_field("found_fidelity", 64'(want.ffid), 64'(found_fidelity));
				compare_field("entries", 64'(want.entries), 64'(entries));
			end
		end
	end

	initial begin : main_flow
		word_t     w;
		answer_t   typed;
		stim_row_t row;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_ROWS; i++) begin
			row = directed_rows[i];
			if (row.kind == ROW_LIMIT) begin
				write_limit(row.limit);
			end else begin
				w.cmd = row.cmd;
				w.rec.key = row.key;
				w.rec.dtype = row.pay[7:0];
				w.rec.low = row.pay;
				w.rec.high = row.pay;
				w.rec.step = row.pay;
				w.rec.fid = row.pay[31:24];
				typed = '0;
				typed.status = row.e_status;
				typed.slot = row.e_slot;
				typed.entries = row.e_entries;
				send_word(w, row.fixed, typed);
			end
		end

		// random phases, mostly lookups so the table fills over several limits
		for (int p = 0; p < 6; p++) begin
			write_limit(phase_limits[p]);
			for (int n = 0; n < RAND_PHASE_WORDS; n++) begin
				if (p == 2 && n == 20)
					hold_off_req = 1'b1;
				w.cmd = ($urandom_range(0, 99) < 40) ? CMD_INSERT : CMD_LOOKUP;
				w.rec.key = pick_key(w.cmd == CMD_INSERT);
				w.rec.dtype = 8'($urandom());
				w.rec.low = $urandom();
				w.rec.high = $urandom();
				w.rec.step = $urandom();
				w.rec.fid = 8'($urandom());
				send_word(w, 1'b0, '0);
			end
		end

		// drain, then watch a while longer for stray result words
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && answers_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * 10);
		$display("Test completed with failures");
		$finish;
	end

endmodule
